### hdl/key_value_table_core_macros.svh
// Assertion macros used by the key/value table core.
`ifndef KEY_VALUE_TABLE_CORE_MACROS_SVH
`define KEY_VALUE_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every clock edge once reset is released.
`define KTC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("key_value_table_core check failed");
// Checked on every clock edge, reset included.
`define KTC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("key_value_table_core check failed");
`else
`define KTC_ASSERT(label, clk, rstn, prop)
`define KTC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### hdl/keytab_pkg.sv
// Package with sizes, codes and helpers for the key/value table.
`default_nettype none

package keytab_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_WIDTH   = 64;
    localparam int VALUE_WIDTH = 64;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int REQ_W        = 3;
    localparam int KEY_PORT_W   = 64;
    localparam int VALUE_PORT_W = 64;
    localparam int LEN_W        = 4;
    localparam int STATUS_W     = 2;
    localparam int TOTAL_W      = 5;
    localparam int MAX_BYTES    = 8;

    localparam int DATA_W = VALUE_WIDTH + LEN_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT    = 3'd0,
        REQ_GET    = 3'd1,
        REQ_DELETE = 3'd2,
        REQ_EXISTS = 3'd3,
        REQ_CLEAR  = 3'd4
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // Outcome of checking one scanned entry.
    typedef struct packed {
        logic hit;
        logic miss;
    } scan_res_t;

    // Byte counts above eight are treated as eight.
    function automatic logic [LEN_W-1:0] sat_bytes(input logic [LEN_W-1:0] nbytes);
        logic [LEN_W-1:0] r;
        r = (nbytes > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : nbytes;
        return r;
    endfunction

    // Mask that keeps the low nbytes bytes of a value word.
    function automatic logic [VALUE_PORT_W-1:0] byte_mask(input logic [LEN_W-1:0] nbytes);
        logic [VALUE_PORT_W-1:0] m;
        m = '0;
        for (int b = 0; b < MAX_BYTES; b++) begin
            if (LEN_W'(b) < nbytes) begin
                m[b*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### hdl/key_value_table_core.sv
// Top level of the linearly searched key/value table.
// A request is one transfer on the s_ channel and always produces exactly one
// transfer on the m_ channel. Put, get, delete and exists search the live
// entries from index 0 upward, one entry per clock, through the single read
// port of the key RAM. A get hit, or a delete that has to move the last
// entry into the freed slot, needs one more RAM read; a search on an empty
// table skips the scan. Clear and unused request codes go straight to
// handing over the result. The block takes one request at a time: s_ready
// is high only while no request is in progress, but it is high even while
// the previous result still waits in the output register. Table contents
// need no clearing after reset, because only entries below the entry count
// are ever read.
`default_nettype none
`include "key_value_table_core_macros.svh"

module key_value_table_core
    import keytab_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [REQ_W-1:0]        s_req_type,
    input  wire logic [KEY_PORT_W-1:0]   s_key,
    input  wire logic [VALUE_PORT_W-1:0] s_value,
    input  wire logic [LEN_W-1:0]        s_value_bytes,

    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [STATUS_W-1:0]          m_status,
    output logic                         m_found,
    output logic [VALUE_PORT_W-1:0]      m_read_value,
    output logic [LEN_W-1:0]             m_read_bytes,
    output logic [TOTAL_W-1:0]           m_entry_total
);

    // Sequencer states: wait for a request, scan the keys, act on the scan
    // result, use data read back from the RAMs, then hand over the result.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_READ,
        S_FINAL
    } state_t;

    state_t                  state_reg, state_next;
    logic [REQ_W-1:0]        req_type_reg, req_type_next;
    logic [KEY_WIDTH-1:0]    key_reg, key_next;
    logic [VALUE_WIDTH-1:0]  value_reg, value_next;
    logic [LEN_W-1:0]        bytes_reg, bytes_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0]        pend_idx_reg, pend_idx_next;
    logic                    hit_reg, hit_next;
    logic [CNT_W-1:0]        hit_idx_reg, hit_idx_next;

    // Result of the request in progress, staged until the output is free.
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic                    res_found_reg, res_found_next;
    logic [VALUE_WIDTH-1:0]  res_value_reg, res_value_next;
    logic [LEN_W-1:0]        res_bytes_reg, res_bytes_next;

    // Output register.
    logic                    m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;
    logic                    m_found_reg, m_found_next;
    logic [VALUE_PORT_W-1:0] m_read_value_reg, m_read_value_next;
    logic [LEN_W-1:0]        m_read_bytes_reg, m_read_bytes_next;
    logic [TOTAL_W-1:0]      m_entry_total_reg, m_entry_total_next;

    // RAM ports. All RAMs share one read address and one write address.
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [KEY_WIDTH-1:0]    wr_key;
    logic [DATA_W-1:0]       wr_data;
    logic [KEY_WIDTH-1:0]    key_rdata;
    logic [DATA_W-1:0]       data_rdata;

    scan_res_t               scan_res;
    logic                    scan_issue;
    logic [CNT_W-1:0]        last_idx;
    logic [LEN_W-1:0]        in_bytes;
    logic [VALUE_PORT_W-1:0] in_mask;

    // The key RAM holds keys; the data RAM holds the byte count above the value.
    keytab_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_key),
        .rd_addr (rd_addr),
        .rd_data (key_rdata)
    );

    keytab_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_data_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (data_rdata)
    );

    // The compare unit looks at the key that was read in the previous cycle.
    keytab_cmp u_cmp (
        .pend_valid  (pend_valid_reg),
        .pend_idx    (pend_idx_reg),
        .entry_count (count_reg),
        .stored_key  (key_rdata),
        .req_key     (key_reg),
        .res         (scan_res)
    );

    assign scan_issue = (scan_idx_reg < count_reg);
    assign last_idx   = CNT_W'(count_reg - 1'b1);
    assign in_bytes   = sat_bytes(s_value_bytes);
    assign in_mask    = byte_mask(in_bytes);

    always_comb begin
        state_next         = state_reg;
        req_type_next      = req_type_reg;
        key_next           = key_reg;
        value_next         = value_reg;
        bytes_next         = bytes_reg;
        count_next         = count_reg;
        scan_idx_next      = scan_idx_reg;
        pend_valid_next    = 1'b0;
        pend_idx_next      = pend_idx_reg;
        hit_next           = hit_reg;
        hit_idx_next       = hit_idx_reg;
        res_status_next    = res_status_reg;
        res_found_next     = res_found_reg;
        res_value_next     = res_value_reg;
        res_bytes_next     = res_bytes_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_status_next      = m_status_reg;
        m_found_next       = m_found_reg;
        m_read_value_next  = m_read_value_reg;
        m_read_bytes_next  = m_read_bytes_reg;
        m_entry_total_next = m_entry_total_reg;

        rd_addr = scan_idx_reg[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = hit_idx_reg[IDX_W-1:0];
        wr_key  = key_reg;
        wr_data = {bytes_reg, value_reg};

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_type_next   = s_req_type;
                    key_next        = s_key[KEY_WIDTH-1:0];
                    value_next      = s_value[VALUE_WIDTH-1:0]
                                    & in_mask[VALUE_WIDTH-1:0];
                    bytes_next      = in_bytes;
                    res_status_next = ST_OK;
                    res_found_next  = 1'b0;
                    res_value_next  = '0;
                    res_bytes_next  = '0;
                    hit_next        = 1'b0;
                    scan_idx_next   = '0;
                    unique case (s_req_type) inside
                        REQ_PUT, REQ_GET, REQ_DELETE, REQ_EXISTS: begin
                            // An empty table needs no scan at all.
                            state_next = (count_reg == '0) ? S_DECIDE : S_SCAN;
                        end
                        REQ_CLEAR: begin
                            count_next = '0;
                            state_next = S_FINAL;
                        end
                        default: begin
                            state_next = S_FINAL;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Issue one key read per cycle and check the one read before.
                if (scan_issue) begin
                    scan_idx_next = CNT_W'(scan_idx_reg + 1'b1);
                end
                pend_valid_next = scan_issue;
                pend_idx_next   = scan_idx_reg;
                if (scan_res.hit) begin
                    hit_next     = 1'b1;
                    hit_idx_next = pend_idx_reg;
                    state_next   = S_DECIDE;
                end else if (scan_res.miss) begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE: begin
                state_next = S_FINAL;
                unique case (req_type_reg)
                    REQ_PUT: begin
                        if (hit_reg) begin
                            wr_en = 1'b1;
                        end else if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                            res_status_next = ST_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[IDX_W-1:0];
                            count_next = CNT_W'(count_reg + 1'b1);
                        end
                    end
                    REQ_GET: begin
                        if (hit_reg) begin
                            rd_addr    = hit_idx_reg[IDX_W-1:0];
                            state_next = S_READ;
                        end else begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    REQ_DELETE: begin
                        if (!hit_reg) begin
                            res_status_next = ST_NOT_FOUND;
                        end else if (hit_idx_reg < last_idx) begin
                            // Fetch the last entry to fill the hole.
                            rd_addr    = last_idx[IDX_W-1:0];
                            state_next = S_READ;
                        end else begin
                            count_next = last_idx;
                        end
                    end
                    REQ_EXISTS: begin
                        res_found_next = hit_reg;
                    end
                    default: begin
                    end
                endcase
            end

            S_READ: begin
                state_next = S_FINAL;
                if (req_type_reg == REQ_GET) begin
                    res_found_next = 1'b1;
                    res_value_next = data_rdata[VALUE_WIDTH-1:0];
                    res_bytes_next = data_rdata[DATA_W-1 -: LEN_W];
                end else begin
                    wr_en      = 1'b1;
                    wr_key     = key_rdata;
                    wr_data    = data_rdata;
                    count_next = last_idx;
                end
            end

            S_FINAL: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_status_next      = res_status_reg;
                    m_found_next       = res_found_reg;
                    m_read_value_next  = VALUE_PORT_W'(res_value_reg);
                    m_read_bytes_next  = res_bytes_reg;
                    m_entry_total_next = TOTAL_W'(count_reg);
                    state_next         = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg         <= state_next;
            req_type_reg      <= req_type_next;
            key_reg           <= key_next;
            value_reg         <= value_next;
            bytes_reg         <= bytes_next;
            count_reg         <= count_next;
            scan_idx_reg      <= scan_idx_next;
            pend_valid_reg    <= pend_valid_next;
            pend_idx_reg      <= pend_idx_next;
            hit_reg           <= hit_next;
            hit_idx_reg       <= hit_idx_next;
            res_status_reg    <= res_status_next;
            res_found_reg     <= res_found_next;
            res_value_reg     <= res_value_next;
            res_bytes_reg     <= res_bytes_next;
            m_valid_reg       <= m_valid_next;
            m_status_reg      <= m_status_next;
            m_found_reg       <= m_found_next;
            m_read_value_reg  <= m_read_value_next;
            m_read_bytes_reg  <= m_read_bytes_next;
            m_entry_total_reg <= m_entry_total_next;
        end
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found       = m_found_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_read_bytes  = m_read_bytes_reg;
    assign m_entry_total = m_entry_total_reg;

    // The entry count never passes the table depth.
    `KTC_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(TABLE_DEPTH))
    // A RAM write lands on a live entry or on the next free slot.
    `KTC_ASSERT(a_write_in_range, aclk, aresetn, wr_en |-> CNT_W'(wr_addr) <= count_reg)
    // Accepting a request closes the input side for the next cycle.
    `KTC_ASSERT(a_one_request, aclk, aresetn, (s_valid && s_ready) |=> !s_ready)
    // Only a put can report a full table.
    `KTC_ASSERT(a_full_is_put, aclk, aresetn,
        (state_reg == S_FINAL && res_status_reg == ST_FULL) |-> req_type_reg == REQ_PUT)

endmodule

`default_nettype wire

### hdl/keytab_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module keytab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      aclk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### hdl/keytab_cmp.sv
// Key compare unit that judges one scanned table entry per cycle.
`default_nettype none

module keytab_cmp
    import keytab_pkg::*;
(
    input  wire logic                 pend_valid,
    input  wire logic [CNT_W-1:0]     pend_idx,
    input  wire logic [CNT_W-1:0]     entry_count,
    input  wire logic [KEY_WIDTH-1:0] stored_key,
    input  wire logic [KEY_WIDTH-1:0] req_key,
    output scan_res_t                 res
);

    logic             key_eq;
    logic [CNT_W-1:0] last_idx;

    assign key_eq   = (stored_key == req_key);
    assign last_idx = CNT_W'(entry_count - 1'b1);

    // A miss is declared once the last live entry has been checked.
    assign res.hit  = pend_valid && key_eq;
    assign res.miss = pend_valid && !key_eq && (pend_idx == last_idx);

endmodule

`default_nettype wire

### tb/key_value_table_core_tb.sv
// Self-checking testbench for the linearly searched key/value table core.
`timescale 1ns / 100ps

module key_value_table_core_tb;
    import keytab_pkg::*;

    // Request codes 5 to 7 are not defined. The table must leave its contents
    // alone and answer them with an all-zero result but for the entry total.
    localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_C = 3'd7;

    localparam int RANDOM_ITEMS  = 700;
    localparam int KEY_POOL_SIZE = 24;
    // The wait after the last expected result is long enough for a stray extra
    // result to show up.
    localparam int TAIL_CYCLES   = 40;
    // The limit sits well above what a slow but correct run needs.
    localparam int CYCLE_LIMIT   = 300000;

    localparam logic [KEY_PORT_W-1:0]   ONES    = '1;
    localparam logic [KEY_PORT_W-1:0]   KEY_MID = 64'h0123_4567_89ab_cdef;
    localparam logic [KEY_PORT_W-1:0]   KEY_ALT = 64'h5555_5555_5555_5555;
    localparam logic [VALUE_PORT_W-1:0] VAL_ALT = 64'haaaa_aaaa_aaaa_aaaa;

    typedef struct packed {
        status_t                 status;
        logic                    found;
        logic [VALUE_PORT_W-1:0] read_value;
        logic [LEN_W-1:0]        read_bytes;
        logic [TOTAL_W-1:0]      entry_total;
    } table_reply_t;

    // One request. When typed is set, reply holds a result written out by
    // hand, and it is used in place of the predicted one.
    typedef struct packed {
        logic [REQ_W-1:0]        op;
        logic [KEY_PORT_W-1:0]   key;
        logic [VALUE_PORT_W-1:0] value;
        logic [LEN_W-1:0]        nbytes;
        logic                    typed;
        table_reply_t            reply;
    } table_request_t;

    // Kinds of random traffic. A fill mix pushes the table up to full, a
    // drain mix empties it again, and a balanced mix is in between.
    typedef enum int {
        MIX_FILL,
        MIX_BALANCED,
        MIX_DRAIN
    } traffic_mix_t;

    localparam table_reply_t NO_REPLY = '{ST_OK, 1'b0, 64'd0, 4'd0, 5'd0};

    localparam int DIRECTED_ROWS = 26;
    localparam int TOTAL_ITEMS   = DIRECTED_ROWS + RANDOM_ITEMS;

    // Directed requests. They start on an empty table, and every count in
    // the hand-written results follows from the rows above it.
    localparam table_request_t DIRECTED [DIRECTED_ROWS] = '{
        // Requests on the empty table, including the undefined codes.
        '{REQ_GET,    64'd0, 64'd0, 4'd0,  1'b1, '{ST_NOT_FOUND, 1'b0, 64'd0, 4'd0, 5'd0}},
        '{REQ_DELETE, ONES,  64'd0, 4'd0,  1'b1, '{ST_NOT_FOUND, 1'b0, 64'd0, 4'd0, 5'd0}},
        '{REQ_EXISTS, ONES,  64'd0, 4'd0,  1'b1, '{ST_OK, 1'b0, 64'd0, 4'd0, 5'd0}},
        '{REQ_RSVD_A, ONES,  ONES,  4'd15, 1'b1, '{ST_OK, 1'b0, 64'd0, 4'd0, 5'd0}},
        '{REQ_RSVD_B, 64'd0, ONES,  4'd8,  1'b1, '{ST_OK, 1'b0, 64'd0, 4'd0, 5'd0}},
        '{REQ_RSVD_C, 64'd0, 64'd0, 4'd0,  1'b1, '{ST_OK, 1'b0, 64'd0, 4'd0, 5'd0}},
        '{REQ_CLEAR,  ONES,  ONES,  4'd15, 1'b1, '{ST_OK, 1'b0, 64'd0, 4'd0, 5'd0}},
        // Extreme keys and a full eight-byte value.
        '{REQ_PUT,    64'd0, ONES,  4'd8,  1'b1, '{ST_OK, 1'b0, 64'd0, 4'd0, 5'd1}},
        '{REQ_GET,    64'd0, 64'd0, 4'd0,  1'b1, '{ST_OK, 1'b1, ONES, 4'd8, 5'd1}},
        // A byte count above eight is treated as eight.
        '{REQ_PUT,    ONES,  ONES,  4'd15, 1'b1, '{ST_OK, 1'b0, 64'd0, 4'd0, 5'd2}},
        '{REQ_GET,    ONES,  64'd0, 4'd0,  1'b1, '{ST_OK, 1'b1, ONES, 4'd8, 5'd2}},
        // Replacing a value keeps only the low bytes that the count allows.
        '{REQ_PUT,    64'd0, ONES,  4'd3,  1'b1, '{ST_OK, 1'b0, 64'd0, 4'd0, 5'd2}},
        '{REQ_GET,    64'd0, 64'd0, 4'd0,  1'b1,
          '{ST_OK, 1'b1, 64'h0000_0000_00ff_ffff, 4'd3, 5'd2}},
        // A put with no bytes stores an empty value.
        '{REQ_PUT,    KEY_MID, ONES, 4'd0, 1'b1, '{ST_OK, 1'b0, 64'd0, 4'd0, 5'd3}},
        '{REQ_GET,    KEY_MID, 64'd0, 4'd0, 1'b1, '{ST_OK, 1'b1, 64'd0, 4'd0, 5'd3}},
        '{REQ_EXISTS, 64'd0, 64'd0, 4'd0,  1'b1, '{ST_OK, 1'b1, 64'd0, 4'd0, 5'd3}},
        '{REQ_PUT,    KEY_ALT, VAL_ALT, 4'd5, 1'b0, NO_REPLY},
        // Deleting entry 0 moves the last entry into its slot.
        '{REQ_DELETE, 64'd0, 64'd0, 4'd0,  1'b1, '{ST_OK, 1'b0, 64'd0, 4'd0, 5'd3}},
        '{REQ_GET,    KEY_ALT, 64'd0, 4'd0, 1'b0, NO_REPLY},
        '{REQ_GET,    64'd0, 64'd0, 4'd0,  1'b1, '{ST_NOT_FOUND, 1'b0, 64'd0, 4'd0, 5'd3}},
        '{REQ_DELETE, KEY_ALT, 64'd0, 4'd0, 1'b0, NO_REPLY},
        // After that move the all-ones key is the last entry.
        '{REQ_DELETE, ONES,  64'd0, 4'd0,  1'b0, NO_REPLY},
        '{REQ_EXISTS, ONES,  64'd0, 4'd0,  1'b0, NO_REPLY},
        '{REQ_PUT,    KEY_ALT, KEY_ALT, 4'd7, 1'b0, NO_REPLY},
        '{REQ_CLEAR,  64'd0, 64'd0, 4'd0,  1'b1, '{ST_OK, 1'b0, 64'd0, 4'd0, 5'd0}},
        '{REQ_GET,    ONES,  64'd0, 4'd0,  1'b1, '{ST_NOT_FOUND, 1'b0, 64'd0, 4'd0, 5'd0}}
    };

    logic                    aclk;
    logic                    aresetn       = 1'b0;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic [REQ_W-1:0]        s_req_type    = '0;
    logic [KEY_PORT_W-1:0]   s_key         = '0;
    logic [VALUE_PORT_W-1:0] s_value       = '0;
    logic [LEN_W-1:0]        s_value_bytes = '0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic [STATUS_W-1:0]     m_status;
    logic                    m_found;
    logic [VALUE_PORT_W-1:0] m_read_value;
    logic [LEN_W-1:0]        m_read_bytes;
    logic [TOTAL_W-1:0]      m_entry_total;

    // The testbench's own copy of the table. Only entries below live_count
    // are ever read, as in the block.
    logic [KEY_PORT_W-1:0]   table_keys [TABLE_DEPTH];
    logic [VALUE_PORT_W-1:0] table_values [TABLE_DEPTH];
    logic [LEN_W-1:0]        table_lengths [TABLE_DEPTH];
    int                      live_count = 0;

    logic [KEY_PORT_W-1:0]   key_pool [KEY_POOL_SIZE];

    // Results still owed by the block, oldest first.
    table_reply_t            awaited_replies [$];

    int                      send_idle_pct = 10;
    int                      recv_idle_pct = 74;
    int                      error_count   = 0;

    key_value_table_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_key         (s_key),
        .s_value       (s_value),
        .s_value_bytes (s_value_bytes),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found       (m_found),
        .m_read_value  (m_read_value),
        .m_read_bytes  (m_read_bytes),
        .m_entry_total (m_entry_total)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Applies one request to the copy of the table and returns the result
    // that the block has to produce for it.
    function automatic table_reply_t apply_request(input table_request_t req);
        table_reply_t            r;
        logic [KEY_PORT_W-1:0]   k;
        logic [VALUE_PORT_W-1:0] v;
        logic [LEN_W-1:0]        n;
        int                      hit;
        r = NO_REPLY;
        k = req.key;
        for (int b = KEY_WIDTH; b < KEY_PORT_W; b++) k[b] = 1'b0;
        n = req.nbytes;
        if (n > LEN_W'(MAX_BYTES)) n = LEN_W'(MAX_BYTES);
        // Keep the low n bytes. Any bits above VALUE_WIDTH are cleared too.
        v = '0;
        for (int b = 0; b < MAX_BYTES; b++) begin
            if (b < n) v[b*8 +: 8] = req.value[b*8 +: 8];
        end
        for (int b = VALUE_WIDTH; b < VALUE_PORT_W; b++) v[b] = 1'b0;
        // The first matching entry wins, as in a scan from index 0.
        hit = -1;
        for (int i = 0; i < live_count; i++) begin
            if (hit < 0 && table_keys[i] == k) hit = i;
        end
        case (req.op)
            REQ_PUT: begin
                if (hit >= 0) begin
                    table_values[hit]  = v;
                    table_lengths[hit] = n;
                end else if (live_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    table_keys[live_count]    = k;
                    table_values[live_count]  = v;
                    table_lengths[live_count] = n;
                    live_count++;
                end
            end
            REQ_GET: begin
                if (hit >= 0) begin
                    r.found      = 1'b1;
                    r.read_value = table_values[hit];
                    r.read_bytes = table_lengths[hit];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            REQ_DELETE: begin
                if (hit >= 0) begin
                    // The last entry fills the hole, unless the hole is the last entry.
                    table_keys[hit]    = table_keys[live_count-1];
                    table_values[hit]  = table_values[live_count-1];
                    table_lengths[hit] = table_lengths[live_count-1];
                    live_count--;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            REQ_EXISTS: r.found = (hit >= 0);
            REQ_CLEAR:  live_count = 0;
            default: ;
        endcase
        r.entry_total = TOTAL_W'(live_count);
        return r;
    endfunction

    // The mix sets the odds of each operation. Undefined codes come up now
    // and then in every mix.
    function automatic logic [REQ_W-1:0] pick_op(input traffic_mix_t mix);
        int unsigned r;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL: begin
                if (r < 78)      return REQ_PUT;
                else if (r < 87) return REQ_GET;
                else if (r < 93) return REQ_EXISTS;
                else if (r < 97) return REQ_DELETE;
            end
            MIX_BALANCED: begin
                if (r < 30)      return REQ_PUT;
                else if (r < 55) return REQ_GET;
                else if (r < 75) return REQ_DELETE;
                else if (r < 91) return REQ_EXISTS;
                else if (r < 94) return REQ_CLEAR;
            end
            default: begin
                if (r < 12)      return REQ_PUT;
                else if (r < 32) return REQ_GET;
                else if (r < 80) return REQ_DELETE;
                else if (r < 93) return REQ_EXISTS;
                else if (r < 95) return REQ_CLEAR;
            end
        endcase
        return REQ_RSVD_A + REQ_W'($urandom_range(2));
    endfunction

    // Keys mostly hit live entries or the small pool, so that the table both
    // fills up and gets hits. Some keys differ from a live key by one bit,
    // and the rest are fresh random words.
    function automatic logic [KEY_PORT_W-1:0] pick_key(input traffic_mix_t mix);
        int unsigned           r;
        int unsigned           live_share;
        logic [KEY_PORT_W-1:0] k;
        r = $urandom_range(99);
        live_share = (mix == MIX_DRAIN) ? 70 : 40;
        k = {$urandom, $urandom};
        if (live_count > 0 && r < live_share) begin
            k = table_keys[$urandom_range(live_count - 1)];
        end else if (live_count > 0 && r < live_share + 10) begin
            k = table_keys[$urandom_range(live_count - 1)];
            k[$urandom_range(KEY_PORT_W - 1)] ^= 1'b1;
        end else if (r < live_share + 25) begin
            k = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        end
        return k;
    endfunction

    // Presents one request, holds it until the block takes it, and records
    // the result owed for it at the edge of the transfer.
    task automatic send_request(input table_request_t req);
        table_reply_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req.op;
        s_key         <= req.key;
        s_value       <= req.value;
        s_value_bytes <= req.nbytes;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_request(req);
        awaited_replies.push_back(req.typed ? req.reply : predicted);
    endtask

    // Stops sending until every owed result has come back, then moves on to
    // new idle rates for the sender and the receiver.
    task automatic quiesce_and_set_idle(input int sender_pct, input int receiver_pct);
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited_replies.size() != 0);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    // Result side. Outputs are read right at the edge, so the values seen
    // are those that the handshake used. m_ready is redrawn every cycle.
    always @(posedge aclk) begin
        table_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_replies.size() == 0) begin
                $error("result transfer with no request outstanding");
                error_count++;
            end else begin
                want = awaited_replies.pop_front();
                if (m_status !== want.status) begin
                    $error("m_status: expected %0d, got %0d", want.status, m_status);
                    error_count++;
                end
                if (m_found !== want.found) begin
                    $error("m_found: expected %0d, got %0d", want.found, m_found);
                    error_count++;
                end
                if (m_read_value !== want.read_value) begin
                    $error("m_read_value: expected %h, got %h", want.read_value, m_read_value);
                    error_count++;
                end
                if (m_read_bytes !== want.read_bytes) begin
                    $error("m_read_bytes: expected %0d, got %0d", want.read_bytes, m_read_bytes);
                    error_count++;
                end
                if (m_entry_total !== want.entry_total) begin
                    $error("m_entry_total: expected %0d, got %0d",
                           want.entry_total, m_entry_total);
                    error_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Ends a run that hangs.
    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        int           sent;
        int           mix_left;
        traffic_mix_t mix;
        table_request_t req;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. The sender idles lightly and the receiver heavily.
        sent = 0;
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_request(DIRECTED[i]);
            sent++;
        end
        // Let the block go fully idle before the random traffic starts.
        quiesce_and_set_idle(send_idle_pct, recv_idle_pct);

        // Random part. It opens with a fill mix so that the table reaches
        // full early. After that the mixes change at random.
        mix      = MIX_FILL;
        mix_left = $urandom_range(60, 45);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (sent == TOTAL_ITEMS / 3) begin
                quiesce_and_set_idle(74, 10);
            end else if (sent == 2 * TOTAL_ITEMS / 3) begin
                quiesce_and_set_idle(0, 0);
            end
            if (mix_left == 0) begin
                mix      = traffic_mix_t'($urandom_range(2));
                mix_left = $urandom_range(50, 20);
            end
            mix_left--;
            req.op     = pick_op(mix);
            req.key    = pick_key(mix);
            req.value  = {$urandom, $urandom};
            req.nbytes = ($urandom_range(99) < 85) ? LEN_W'($urandom_range(MAX_BYTES))
                                                   : LEN_W'($urandom_range(15, MAX_BYTES + 1));
            req.typed  = 1'b0;
            req.reply  = NO_REPLY;
            send_request(req);
            sent++;
        end
        s_valid <= 1'b0;
        recv_idle_pct = 0;

        // Wait for the owed results, then a little longer to catch extras.
        while (awaited_replies.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && awaited_replies.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/keytab_pkg.sv
hdl/keytab_ram.sv
hdl/keytab_cmp.sv
hdl/key_value_table_core.sv
tb/key_value_table_core_tb.sv
